// ===== hdl/bfbp_pkg.sv =====
// Package: widths, types and codes shared by the best-fit bin packing block.
`default_nettype none
package bfbp_pkg;
  localparam int unsigned MaxBins   = 64;
  localparam int unsigned SizeBits  = 48;
  localparam int unsigned IdxBits   = $clog2(MaxBins);
  localparam int unsigned CntBits   = $clog2(MaxBins + 1);
  localparam int unsigned LabelW    = 6;
  localparam int unsigned CountW    = 7;
  localparam int unsigned FieldW    = 48;
  localparam int unsigned AddrW     = 3;
  localparam logic [SizeBits-1:0] CapReset = SizeBits'(1000);

  localparam logic [AddrW-1:0] RegCapacity = 3'd0;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrTooBig  = 2'd1,
    ErrNoBin   = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StPlace = 3'b010,
    StDone  = 3'b100
  } state_e;

  typedef struct packed {
    logic load;   // latch item, clear if requested
    logic place;  // compare all bins, insert
  } cmd_t;

  typedef struct packed {
    logic             too_big;
    logic             found;
    logic [IdxBits-1:0] slot;
  } stat_t;
endpackage
`default_nettype wire

// ===== hdl/bfbp_ctrl.sv =====
// Controller: sequences load, place and result strobe for one item.
`default_nettype none
module bfbp_ctrl import bfbp_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  output logic busy_o,
  output cmd_t cmd_o,
  output logic done_o
);
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StPlace;
        end
      end
      StPlace: begin
        cmd_o.place = 1'b1;
        state_d     = StDone;
      end
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end
endmodule
`default_nettype wire

// ===== hdl/bfbp_dp.sv =====
// Datapath: sorted bin array, parallel fit compare, shifting insert, result regs.
`default_nettype none
module bfbp_dp import bfbp_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  cmd_t                cmd_i,
  input  wire  [SizeBits-1:0] cap_i,
  input  wire  [SizeBits-1:0] size_i,
  input  wire                 clear_i,
  output logic [LabelW-1:0]   label_o,
  output logic [CountW-1:0]   count_o,
  output err_e                err_o
);
  logic [SizeBits-1:0] fill_q [MaxBins];
  logic [IdxBits-1:0]  tag_q  [MaxBins];
  logic [CntBits-1:0]  open_q;
  logic [SizeBits-1:0] size_q;
  logic                too_q;
  logic [MaxBins-1:0]  fit;
  logic [MaxBins-1:0]  less;
  logic [MaxBins-1:0]  shl;
  logic [SizeBits-1:0] newsum;
  stat_t               st;

  // one extra bit: the sum of item size and fill level cannot wrap around
  always_comb begin
    for (int p = 0; p < MaxBins; p++)
      fit[p] = (({1'b0, size_q} + {1'b0, fill_q[p]}) <= {1'b0, cap_i});
  end

  always_comb begin
    st.found = |fit;
    st.slot  = '0;
    for (int p = MaxBins - 1; p >= 0; p--)
      if (fit[p]) st.slot = IdxBits'(p);
    st.too_big = too_q;
  end

  assign newsum = fill_q[st.slot] + size_q;

  // bins above the target that are strictly less full shift down one place
  always_comb begin
    for (int p = 0; p < MaxBins; p++)
      less[p] = (fill_q[p] < newsum);
  end

  // shl[p]: position p takes the entry from p-1
  assign shl = {less[MaxBins-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < MaxBins; p++) begin
        fill_q[p] <= '0;
        tag_q[p]  <= IdxBits'(p);
      end
      open_q <= '0;
      too_q  <= 1'b0;
    end else if (cmd_i.load) begin
      if (clear_i) begin
        for (int p = 0; p < MaxBins; p++) begin
          fill_q[p] <= '0;
          tag_q[p]  <= IdxBits'(p);
        end
        open_q <= '0;
      end
      too_q <= (size_i > cap_i);
    end else if (cmd_i.place && !too_q && st.found) begin
      for (int p = 0; p < MaxBins; p++) begin
        if (IdxBits'(p) <= st.slot) begin
          if (shl[p]) begin
            fill_q[p] <= fill_q[p-1];
            tag_q[p]  <= tag_q[p-1];
          end else if (less[p] || IdxBits'(p) == st.slot) begin
            fill_q[p] <= newsum;
            tag_q[p]  <= tag_q[st.slot];
          end
        end
      end
      if ({1'b0, st.slot} >= open_q) open_q <= open_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) size_q <= size_i;
    if (cmd_i.place) begin
      if (too_q) begin
        err_o   <= ErrTooBig;
        label_o <= '0;
        count_o <= CountW'(open_q);
      end else if (!st.found) begin
        err_o   <= ErrNoBin;
        label_o <= '0;
        count_o <= CountW'(open_q);
      end else begin
        err_o   <= ErrNone;
        label_o <= LabelW'(tag_q[st.slot]);
        count_o <= ({1'b0, st.slot} >= open_q) ? CountW'(open_q + 1'b1)
                                               : CountW'(open_q);
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/best_fit_bin_packing_core.sv =====
// Top level: best-fit bin packing over a sorted array of bins.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------
//  item in   | start / busy         | item_size_i, start_new_i
//  result    | result_valid_o       | bin_label_o, bins_in_use_o, error_code_o
//  config    | APB psel/penable     | bin_capacity at byte address 0
//
// The item is loaded (and the bins cleared if asked) at the accepting edge, the
// next cycle does the parallel fit compares plus shifting insert over all 64
// bins, then the strobe cycle follows. busy covers the place and strobe cycles,
// so a new item is not accepted until the result strobe is over.
// Reset puts all bins empty with labels equal to position and capacity 1000.
// The result beat lasts one cycle; the receiver cannot stall it.
`default_nettype none
module best_fit_bin_packing_core import bfbp_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  [FieldW-1:0]  item_size_i,
  input  wire                start_new_i,
  output logic               result_valid_o,
  output logic [LabelW-1:0]  bin_label_o,
  output logic [CountW-1:0]  bins_in_use_o,
  output logic [1:0]         error_code_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [AddrW-1:0]   paddr,
  input  wire  [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  cmd_t                cmd;
  err_e                err;
  logic [SizeBits-1:0] cap_q;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapReset;
    else if (psel && penable && pwrite && paddr == RegCapacity)
      cap_q <= pwdata[SizeBits-1:0];
  end
  assign prdata = (paddr == RegCapacity) ? 64'(cap_q) : '0;

  bfbp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .cmd_o(cmd),
    .done_o(result_valid_o)
  );

  bfbp_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cap_i(cap_q),
    .size_i(item_size_i[SizeBits-1:0]), .clear_i(start_new_i),
    .label_o(bin_label_o), .count_o(bins_in_use_o), .err_o(err)
  );
  assign error_code_o = err;
endmodule
`default_nettype wire

// ===== hdl/bfbp_checker.sv =====
// Checker: port-level properties of the bin packing core, bound to the top.
`default_nettype none
module bfbp_checker import bfbp_pkg::*; (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              start,
  input wire              busy,
  input wire              result_valid_o,
  input wire [LabelW-1:0] bin_label_o,
  input wire [CountW-1:0] bins_in_use_o,
  input wire [1:0]        error_code_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");
  a_result_two_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 result_valid_o) else $error("result missing");
  a_err_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && error_code_o != 2'd0 |-> bin_label_o == '0)
    else $error("label on error");
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> error_code_o != 2'd3 && bins_in_use_o <= CountW'(MaxBins))
    else $error("result out of range");
endmodule

bind best_fit_bin_packing_core bfbp_checker u_chk (.*);
`default_nettype wire
